FILE: hw/rtl/sast_pkg.sv
// Shared widths, codes and controller interface types for the spawn admission table.
`default_nettype none

package sast_pkg;

    localparam int KEY_W      = 224;
    localparam int SCORE_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int SEC_W      = 32;
    localparam int ENTRY_W    = KEY_W + SCORE_W + COUNT_W + SEC_W;
    localparam int PEN_W      = 9;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int VERDICT_W  = 3;
    localparam int KIND_W     = 2;
    // score + penalty - elapsed needs two bits above the elapsed width
    localparam int SUM_W      = SEC_W + 2;

    localparam logic [KIND_W-1:0] KIND_SPAWN     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXIT      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SPAWN_QRY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_KILL_QRY  = 2'd3;

    localparam logic [VERDICT_W-1:0] VERDICT_OK         = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_SCORE_HIGH = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_TOTAL_HIGH = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_CLASS_FULL = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_TABLE_FULL = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_CLASS_MIN  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_PEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_PEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_MIN   = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    typedef struct packed {
        logic load;
        logic scan;
        logic elapse;
        logic score;
        logic commit;
    } sast_cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_end;
    } sast_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sast_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AddrW-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AddrW-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sast_ctrl.sv
// Sequencing state machine: scan, decay, commit and result strobe.
`default_nettype none

module sast_ctrl
    import sast_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire sast_stat_t stat,
    output sast_cmd_t       cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ELAPSE,
        ST_SCORE,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.scan_end)
                begin
                    state_next = ST_ELAPSE;
                end
            end
            ST_ELAPSE:
            begin
                cmd.elapse = 1'b1;
                state_next = ST_SCORE;
            end
            ST_SCORE:
            begin
                cmd.score  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
            done_reg  <= (state_reg == ST_COMMIT);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sast_dp.sv
// Datapath: class table, key scan, score decay, count updates and configuration.
`default_nettype none

module sast_dp
    import sast_pkg::*;
#(
    parameter int CLASS_ENTRIES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sast_cmd_t             cmd,
    output sast_stat_t                 stat,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [63:0]           file_inode,
    input  wire logic [63:0]           device_id,
    input  wire logic [31:0]           share_group,
    input  wire logic [31:0]           user_id,
    input  wire logic [31:0]           group_id,
    input  wire logic [SEC_W-1:0]      now_sec,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic      [VERDICT_W-1:0]  verdict,
    output logic      [SCORE_W-1:0]    class_score,
    output logic      [COUNT_W-1:0]    class_count,
    output logic      [COUNT_W-1:0]    total_count
);

    localparam int IdxW  = (CLASS_ENTRIES > 1) ? $clog2(CLASS_ENTRIES) : 1;
    localparam int FillW = $clog2(CLASS_ENTRIES + 1);

    // configuration
    logic signed [PEN_W-1:0]   spawn_pen_reg;
    logic signed [PEN_W-1:0]   exit_pen_reg;
    logic        [LIMIT_W-1:0] score_limit_reg;
    logic        [LIMIT_W-1:0] total_limit_reg;
    logic        [LIMIT_W-1:0] class_max_reg;
    logic        [LIMIT_W-1:0] class_min_reg;

    // request and scan state
    logic [KIND_W-1:0]  kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SEC_W-1:0]   now_reg;
    logic [FillW-1:0]   scan_addr_reg;
    logic               cmp_vld_reg;
    logic [IdxW-1:0]    cmp_idx_reg;
    logic               hit_reg;
    logic [IdxW-1:0]    hit_idx_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SEC_W-1:0]   last_reg;
    logic [SEC_W-1:0]   elapsed_reg;
    logic [SCORE_W-1:0] new_score_reg;
    logic [FillW-1:0]   fill_reg;
    logic [COUNT_W-1:0] total_reg;

    logic [VERDICT_W-1:0] verdict_reg;
    logic [SCORE_W-1:0]   cscore_reg;
    logic [COUNT_W-1:0]   ccount_reg;

    // table
    logic                 ram_we;
    logic [IdxW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [KEY_W-1:0]     rd_key;
    logic [SCORE_W-1:0]   rd_score;
    logic [COUNT_W-1:0]   rd_count;
    logic [SEC_W-1:0]     rd_last;

    logic issue;
    logic hit_now;

    logic signed [PEN_W-1:0] delta;
    logic signed [SUM_W-1:0] sum;
    logic [SCORE_W-1:0]      clamped;

    logic                 table_free;
    logic [COUNT_W-1:0]   count_inc;
    logic [COUNT_W-1:0]   count_dec;
    logic [COUNT_W-1:0]   total_inc;
    logic [COUNT_W-1:0]   total_dec;
    logic [VERDICT_W-1:0] verdict_next;
    logic [SCORE_W-1:0]   cscore_next;
    logic [COUNT_W-1:0]   ccount_next;
    logic [COUNT_W-1:0]   total_next;
    logic [FillW-1:0]     fill_next;

    sast_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CLASS_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_addr_reg[IdxW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[ENTRY_W-1 -: KEY_W];
    assign rd_score = ram_rdata[SCORE_W+COUNT_W+SEC_W-1 -: SCORE_W];
    assign rd_count = ram_rdata[COUNT_W+SEC_W-1 -: COUNT_W];
    assign rd_last  = ram_rdata[SEC_W-1:0];

    // Valid entries always form a prefix, so the fill count bounds the scan.
    assign hit_now       = cmd.scan && cmp_vld_reg && (rd_key == key_reg);
    assign issue         = cmd.scan && !hit_now && (scan_addr_reg < fill_reg);
    assign stat.hit      = hit_now;
    assign stat.scan_end = cmd.scan && !cmp_vld_reg && (scan_addr_reg >= fill_reg);

    // Decay: score + penalty - elapsed, clamped to the score range.
    always_comb
    begin
        case (kind_reg)
            KIND_SPAWN: delta = spawn_pen_reg;
            KIND_EXIT:  delta = exit_pen_reg;
            default:    delta = '0;
        endcase
        sum = $signed({{(SUM_W-SCORE_W){1'b0}}, score_reg})
            + $signed({{(SUM_W-PEN_W){delta[PEN_W-1]}}, delta})
            - $signed({{(SUM_W-SEC_W){1'b0}}, elapsed_reg});
        if (sum[SUM_W-1])
        begin
            clamped = '0;
        end
        else if (|sum[SUM_W-2:SCORE_W])
        begin
            clamped = SCORE_MAX;
        end
        else
        begin
            clamped = sum[SCORE_W-1:0];
        end
    end

    assign table_free = (fill_reg < FillW'(CLASS_ENTRIES));
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign count_dec  = (count_reg == '0) ? count_reg : count_reg - 1'b1;
    assign total_inc  = (total_reg == COUNT_MAX) ? total_reg : total_reg + 1'b1;
    assign total_dec  = (total_reg == '0) ? total_reg : total_reg - 1'b1;

    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = hit_idx_reg;
        ram_wdata    = {key_reg, new_score_reg, count_reg, now_reg};
        verdict_next = VERDICT_OK;
        cscore_next  = '0;
        ccount_next  = '0;
        total_next   = total_reg;
        fill_next    = fill_reg;
        case (kind_reg)
            KIND_SPAWN, KIND_EXIT:
            begin
                total_next = (kind_reg == KIND_SPAWN) ? total_inc : total_dec;
                if (hit_reg)
                begin
                    ram_we      = cmd.commit;
                    ccount_next = (kind_reg == KIND_SPAWN) ? count_inc : count_dec;
                    cscore_next = new_score_reg;
                    ram_wdata   = {key_reg, new_score_reg, ccount_next, now_reg};
                end
                else if (table_free)
                begin
                    ram_we      = cmd.commit;
                    ram_waddr   = fill_reg[IdxW-1:0];
                    ccount_next = COUNT_W'(1);
                    ram_wdata   = {key_reg, {SCORE_W{1'b0}}, ccount_next, now_reg};
                    fill_next   = fill_reg + 1'b1;
                end
                else
                begin
                    verdict_next = VERDICT_TABLE_FULL;
                end
            end
            KIND_SPAWN_QRY:
            begin
                if (hit_reg)
                begin
                    ram_we      = cmd.commit;
                    cscore_next = new_score_reg;
                    ccount_next = count_reg;
                    if (new_score_reg >= score_limit_reg)
                    begin
                        verdict_next = VERDICT_SCORE_HIGH;
                    end
                    else if (total_reg >= total_limit_reg)
                    begin
                        verdict_next = VERDICT_TOTAL_HIGH;
                    end
                    else if (count_reg >= class_max_reg)
                    begin
                        verdict_next = VERDICT_CLASS_FULL;
                    end
                end
            end
            default:
            begin
                // kill query reads only
                if (hit_reg)
                begin
                    cscore_next = score_reg;
                    ccount_next = count_reg;
                    if (count_reg <= class_min_reg)
                    begin
                        verdict_next = VERDICT_CLASS_MIN;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spawn_pen_reg   <= PEN_W'(1);
            exit_pen_reg    <= PEN_W'(2);
            score_limit_reg <= LIMIT_W'(10);
            total_limit_reg <= LIMIT_W'(1000);
            class_max_reg   <= LIMIT_W'(100);
            class_min_reg   <= LIMIT_W'(3);
            fill_reg        <= '0;
            total_reg       <= '0;
            cmp_vld_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            scan_addr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPAWN_PEN:   spawn_pen_reg   <= cfg_data[PEN_W-1:0];
                    CFG_EXIT_PEN:    exit_pen_reg    <= cfg_data[PEN_W-1:0];
                    CFG_SCORE_LIMIT: score_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_TOTAL_LIMIT: total_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_CLASS_MAX:   class_max_reg   <= cfg_data[LIMIT_W-1:0];
                    CFG_CLASS_MIN:   class_min_reg   <= cfg_data[LIMIT_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.load)
            begin
                scan_addr_reg <= '0;
                cmp_vld_reg   <= 1'b0;
                hit_reg       <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_vld_reg <= issue;
                if (issue)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                if (hit_now)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                total_reg <= total_next;
                fill_reg  <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= {file_inode, device_id, share_group, user_id, group_id};
            now_reg  <= now_sec;
        end
        if (cmd.scan)
        begin
            cmp_idx_reg <= scan_addr_reg[IdxW-1:0];
        end
        if (hit_now)
        begin
            hit_idx_reg <= cmp_idx_reg;
            score_reg   <= rd_score;
            count_reg   <= rd_count;
            last_reg    <= rd_last;
        end
        if (cmd.elapse)
        begin
            elapsed_reg <= now_reg - last_reg;
        end
        if (cmd.score)
        begin
            new_score_reg <= clamped;
        end
        if (cmd.commit)
        begin
            verdict_reg <= verdict_next;
            cscore_reg  <= cscore_next;
            ccount_reg  <= ccount_next;
        end
    end

    assign verdict     = verdict_reg;
    assign class_score = cscore_reg;
    assign class_count = ccount_reg;
    assign total_count = total_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/spawn_admission_score_table.sv
// Top level of the spawn admission score table.
//
// Requests: raise start with kind and the class key (file_inode, device_id,
// share_group, user_id, group_id) and now_sec; the request is taken at a
// rising edge with start high and busy low. busy stays high until the
// result has been formed.
// Results: done is high for exactly one cycle while verdict, class_score,
// class_count and total_count carry the answer; the receiver cannot stall,
// so the result must be taken in that cycle. A new request may be taken in
// the same cycle as done.
// Sequence: the request runs the scan, elapse, score and commit states and
// done follows commit. With no match the scan covers every class in use;
// a match at slot k ends the scan early. The key search reads one table slot
// per cycle from a single RAM read port, so the worst case scans all
// CLASS_ENTRIES slots; no new request is taken until busy is low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while busy is low.
// Reset: clears the table fill count and process total and loads the
// register defaults; no clearing pass is needed.
`default_nettype none

module spawn_admission_score_table
    import sast_pkg::*;
#(
    parameter int CLASS_ENTRIES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [63:0]           file_inode,
    input  wire logic [63:0]           device_id,
    input  wire logic [31:0]           share_group,
    input  wire logic [31:0]           user_id,
    input  wire logic [31:0]           group_id,
    input  wire logic [SEC_W-1:0]      now_sec,
    output logic                       done,
    output logic      [VERDICT_W-1:0]  verdict,
    output logic      [SCORE_W-1:0]    class_score,
    output logic      [COUNT_W-1:0]    class_count,
    output logic      [COUNT_W-1:0]    total_count,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    sast_cmd_t  cmd;
    sast_stat_t stat;
    logic       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    sast_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sast_dp #(
        .CLASS_ENTRIES (CLASS_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .file_inode  (file_inode),
        .device_id   (device_id),
        .share_group (share_group),
        .user_id     (user_id),
        .group_id    (group_id),
        .now_sec     (now_sec),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .verdict     (verdict),
        .class_score (class_score),
        .class_count (class_count),
        .total_count (total_count)
    );

endmodule

`default_nettype wire
